@@ rtl/core/texture_subresource_layout_core_defines.svh @@
// assertion macros for the texture subresource layout core
`ifndef TEXTURE_SUBRESOURCE_LAYOUT_CORE_DEFINES_SVH
`define TEXTURE_SUBRESOURCE_LAYOUT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TSL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TSL_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define TSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/core/tsl_pkg.sv @@
// shared types and constants of the texture subresource layout core
`default_nettype none
package tsl_pkg;

  localparam int MAX_LEVELS = 15;
  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LCNT_W = $clog2(MAX_LEVELS + 1);

  localparam logic [2:0] CFG_BLOCK_BYTES  = 3'd0;
  localparam logic [2:0] CFG_BLOCK_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_BLOCK_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_BLOCK_DEPTH  = 3'd3;
  localparam logic [2:0] CFG_ALIGN_BYTES  = 3'd4;

  localparam logic [4:0] RST_BLOCK_BYTES  = 5'd4;
  localparam logic [3:0] RST_BLOCK_DIM    = 4'd1;
  localparam logic [8:0] RST_ALIGN_BYTES  = 9'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLK_START,
    ST_BLK_WAIT,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_ALN_START,
    ST_ALN_WAIT,
    ST_ACCUM,
    ST_TOTAL,
    ST_ERROR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic blk_start;
    logic mul1;
    logic mul2;
    logic mul3;
    logic aln_start;
    logic accum;
    logic total;
    logic emit;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    logic blk_done;
    logic aln_done;
    logic lvl_last;
    logic layer_err;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/core/tsl_div.sv @@
// serial divider, four quotient bits per cycle, 9-bit divisor
`default_nettype none
module tsl_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        narrow,
  input  wire logic [31:0] dividend,
  input  wire logic [8:0]  divisor,
  output logic [31:0]      quotient,
  output logic [8:0]       remainder,
  output logic             done
);

  logic        active;
  logic [2:0]  cnt;
  logic [8:0]  dsor;
  logic [8:0]  rem;
  logic [8:0]  rem_next;
  logic [31:0] quo;
  logic [31:0] quo_next;
  logic [31:0] dvd;
  logic [31:0] dvd_next;

  always_comb begin : nibble
    logic [9:0]  t;
    logic [8:0]  r;
    logic [31:0] q;
    logic [31:0] dv;
    r = rem;
    q = quo;
    dv = dvd;
    for (int k = 0; k < 4; k++) begin
      t = {r, dv[31]};
      if (t >= {1'b0, dsor}) begin
        r = 9'(t - {1'b0, dsor});
        q = {q[30:0], 1'b1};
      end else begin
        r = t[8:0];
        q = {q[30:0], 1'b0};
      end
      dv = {dv[30:0], 1'b0};
    end
    rem_next = r;
    quo_next = q;
    dvd_next = dv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= narrow ? 3'd3 : 3'd7;
      end else if (active) begin
        cnt <= cnt - 3'd1;
        if (cnt == 3'd0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= '0;
      dvd  <= narrow ? {dividend[15:0], 16'h0000} : dividend;
      dsor <= (divisor == 9'd0) ? 9'd1 : divisor;
    end else if (active) begin
      rem <= rem_next;
      quo <= quo_next;
      dvd <= dvd_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

@@ rtl/core/tsl_ctrl.sv @@
// controller state machine sequencing the level walk and record output
`default_nettype none
module tsl_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire tsl_pkg::sts_t sts,
  output tsl_pkg::cmd_t     cmd,
  output logic              busy
);

  tsl_pkg::state_t state;
  tsl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tsl_pkg::ST_IDLE: begin
        if (start) state_next = tsl_pkg::ST_BLK_START;
      end
      tsl_pkg::ST_BLK_START: state_next = tsl_pkg::ST_BLK_WAIT;
      tsl_pkg::ST_BLK_WAIT: begin
        if (sts.blk_done) state_next = tsl_pkg::ST_MUL1;
      end
      tsl_pkg::ST_MUL1: state_next = tsl_pkg::ST_MUL2;
      tsl_pkg::ST_MUL2: state_next = tsl_pkg::ST_MUL3;
      tsl_pkg::ST_MUL3: state_next = tsl_pkg::ST_ALN_START;
      tsl_pkg::ST_ALN_START: state_next = tsl_pkg::ST_ALN_WAIT;
      tsl_pkg::ST_ALN_WAIT: begin
        if (sts.aln_done) state_next = tsl_pkg::ST_ACCUM;
      end
      tsl_pkg::ST_ACCUM: begin
        state_next = sts.lvl_last ? tsl_pkg::ST_TOTAL : tsl_pkg::ST_BLK_START;
      end
      tsl_pkg::ST_TOTAL: begin
        state_next = sts.layer_err ? tsl_pkg::ST_ERROR : tsl_pkg::ST_EMIT;
      end
      tsl_pkg::ST_ERROR: state_next = tsl_pkg::ST_IDLE;
      tsl_pkg::ST_EMIT: begin
        if (sts.lvl_last) state_next = tsl_pkg::ST_IDLE;
      end
      default: state_next = tsl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      tsl_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      tsl_pkg::ST_BLK_START: cmd.blk_start = 1'b1;
      tsl_pkg::ST_BLK_WAIT:  cmd = '0;
      tsl_pkg::ST_MUL1:      cmd.mul1 = 1'b1;
      tsl_pkg::ST_MUL2:      cmd.mul2 = 1'b1;
      tsl_pkg::ST_MUL3:      cmd.mul3 = 1'b1;
      tsl_pkg::ST_ALN_START: cmd.aln_start = 1'b1;
      tsl_pkg::ST_ALN_WAIT:  cmd = '0;
      tsl_pkg::ST_ACCUM:     cmd.accum = 1'b1;
      tsl_pkg::ST_TOTAL:     cmd.total = 1'b1;
      tsl_pkg::ST_ERROR:     cmd.emit_err = 1'b1;
      tsl_pkg::ST_EMIT:      cmd.emit = 1'b1;
      default:               cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/tsl_dp.sv @@
// datapath: config registers, level size arithmetic, level table and record output
`default_nettype none
module tsl_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wen,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [8:0]    cfg_data,
  input  wire logic [14:0]   tex_width,
  input  wire logic [14:0]   tex_height,
  input  wire logic [11:0]   tex_depth,
  input  wire logic [3:0]    level_count,
  input  wire logic [11:0]   array_count,
  input  wire logic          cube_mode,
  input  wire logic [13:0]   layer_index,
  input  wire tsl_pkg::cmd_t cmd,
  output tsl_pkg::sts_t      sts,
  output logic               valid,
  output logic [31:0]        byte_offset,
  output logic [31:0]        byte_size,
  output logic [14:0]        row_texels,
  output logic [14:0]        row_count,
  output logic [3:0]         level_number,
  output logic [31:0]        total_bytes,
  output logic               status,
  output logic               last
);

  typedef struct packed {
    logic [31:0] size;
    logic [31:0] slot;
    logic [14:0] texels;
    logic [14:0] rows;
  } lvl_rec_t;

  logic [4:0] blk_bytes;
  logic [3:0] blk_w;
  logic [3:0] blk_h;
  logic [3:0] blk_d;
  logic [8:0] aln;

  logic [14:0] tw;
  logic [14:0] th;
  logic [11:0] td;
  logic [tsl_pkg::LCNT_W-1:0] levels;
  logic [tsl_pkg::LCNT_W-1:0] levels_next;
  logic [14:0] layers;
  logic [13:0] layer;

  logic [tsl_pkg::LVL_W-1:0] lvl;
  logic [31:0] stride;
  logic [31:0] off;
  logic [31:0] total;

  logic [14:0] ew;
  logic [14:0] eh;
  logic [11:0] ed;
  logic [3:0]  xw;
  logic [3:0]  xh;
  logic [8:0]  aln_eff;

  logic [31:0] qw, qh, qd, qa;
  logic [8:0]  rw, rh, rd, ra;
  logic        dw_done, dh_done, dd_done, da_done;

  logic [14:0] bw;
  logic [14:0] bh;
  logic [11:0] bd;
  logic [14:0] bh_r;
  logic [11:0] bd_r;
  logic [19:0] s1;
  logic [31:0] s2;
  logic [31:0] s3;
  logic [14:0] rt;
  logic [14:0] rc;
  logic [18:0] rt_full;
  logic [18:0] rc_full;
  logic [31:0] slot;

  lvl_rec_t recs [tsl_pkg::MAX_LEVELS];

  // mip extents, minimum one
  assign ew = ((tw >> lvl) == 15'd0) ? 15'd1 : (tw >> lvl);
  assign eh = ((th >> lvl) == 15'd0) ? 15'd1 : (th >> lvl);
  assign ed = ((td >> lvl) == 12'd0) ? 12'd1 : (td >> lvl);

  assign xw = (blk_w == 4'd0) ? 4'd1 : blk_w;
  assign xh = (blk_h == 4'd0) ? 4'd1 : blk_h;
  assign aln_eff = (aln == 9'd0) ? 9'd1 : aln;

  tsl_div u_div_w (
    .clk, .rst, .start(cmd.blk_start), .narrow(1'b1),
    .dividend(32'(ew)), .divisor({5'd0, blk_w}),
    .quotient(qw), .remainder(rw), .done(dw_done)
  );

  tsl_div u_div_h (
    .clk, .rst, .start(cmd.blk_start), .narrow(1'b1),
    .dividend(32'(eh)), .divisor({5'd0, blk_h}),
    .quotient(qh), .remainder(rh), .done(dh_done)
  );

  tsl_div u_div_d (
    .clk, .rst, .start(cmd.blk_start), .narrow(1'b1),
    .dividend(32'(ed)), .divisor({5'd0, blk_d}),
    .quotient(qd), .remainder(rd), .done(dd_done)
  );

  tsl_div u_div_a (
    .clk, .rst, .start(cmd.aln_start), .narrow(1'b0),
    .dividend(s3), .divisor(aln),
    .quotient(qa), .remainder(ra), .done(da_done)
  );

  // ceiling of the block counts
  assign bw = qw[14:0] + 15'(rw != 9'd0);
  assign bh = qh[14:0] + 15'(rh != 9'd0);
  assign bd = qd[11:0] + 12'(rd != 9'd0);

  assign rt_full = 19'(bw) * 19'(xw);
  assign rc_full = 19'(bh) * 19'(xh);

  // size rounded up to the alignment, wraps at 32 bits
  assign slot = (ra == 9'd0) ? s3 : (s3 + 32'(aln_eff - ra));

  always_comb begin
    if (level_count == 4'd0) begin
      levels_next = tsl_pkg::LCNT_W'(1);
    end else if (32'(level_count) > tsl_pkg::MAX_LEVELS) begin
      levels_next = tsl_pkg::LCNT_W'(tsl_pkg::MAX_LEVELS);
    end else begin
      levels_next = tsl_pkg::LCNT_W'(level_count);
    end
  end

  assign sts.blk_done  = dw_done & dh_done & dd_done;
  assign sts.aln_done  = da_done;
  assign sts.lvl_last  = (tsl_pkg::LCNT_W'(lvl) + tsl_pkg::LCNT_W'(1)) == levels;
  assign sts.layer_err = {1'b0, layer} >= layers;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_bytes <= tsl_pkg::RST_BLOCK_BYTES;
      blk_w     <= tsl_pkg::RST_BLOCK_DIM;
      blk_h     <= tsl_pkg::RST_BLOCK_DIM;
      blk_d     <= tsl_pkg::RST_BLOCK_DIM;
      aln       <= tsl_pkg::RST_ALIGN_BYTES;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        tsl_pkg::CFG_BLOCK_BYTES:  blk_bytes <= cfg_data[4:0];
        tsl_pkg::CFG_BLOCK_WIDTH:  blk_w     <= cfg_data[3:0];
        tsl_pkg::CFG_BLOCK_HEIGHT: blk_h     <= cfg_data[3:0];
        tsl_pkg::CFG_BLOCK_DEPTH:  blk_d     <= cfg_data[3:0];
        tsl_pkg::CFG_ALIGN_BYTES:  aln       <= cfg_data;
        default: ;
      endcase
    end
  end

  // input beat latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tw     <= tex_width;
      th     <= tex_height;
      td     <= tex_depth;
      levels <= levels_next;
      layers <= cube_mode ? (15'({array_count, 2'b00}) + 15'({array_count, 1'b0}))
                          : 15'(array_count);
      layer  <= layer_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl    <= '0;
      stride <= '0;
    end else if (cmd.load || cmd.total) begin
      lvl <= '0;
      if (cmd.load) stride <= '0;
    end else if (cmd.accum) begin
      stride <= stride + slot;
      if (!sts.lvl_last) lvl <= lvl + tsl_pkg::LVL_W'(1);
    end else if (cmd.emit && !sts.lvl_last) begin
      lvl <= lvl + tsl_pkg::LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      s1   <= 20'(blk_bytes) * 20'(bw);
      rt   <= rt_full[14:0];
      rc   <= rc_full[14:0];
      bh_r <= bh;
      bd_r <= bd;
    end
    if (cmd.mul2) s2 <= 32'(s1) * 32'(bh_r);
    if (cmd.mul3) s3 <= s2 * 32'(bd_r);
    if (cmd.accum) begin
      recs[lvl] <= '{size: s3, slot: slot, texels: rt, rows: rc};
    end
    if (cmd.total) begin
      total <= 32'(layers) * stride;
      off   <= 32'(layer) * stride;
    end else if (cmd.emit) begin
      off <= off + recs[lvl].slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit | cmd.emit_err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      byte_offset  <= off;
      byte_size    <= recs[lvl].size;
      row_texels   <= recs[lvl].texels;
      row_count    <= recs[lvl].rows;
      level_number <= 4'(lvl);
      total_bytes  <= total;
      status       <= 1'b0;
      last         <= sts.lvl_last;
    end else if (cmd.emit_err) begin
      byte_offset  <= '0;
      byte_size    <= '0;
      row_texels   <= '0;
      row_count    <= '0;
      level_number <= '0;
      total_bytes  <= total;
      status       <= 1'b1;
      last         <= 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/texture_subresource_layout_core.sv @@
// top level of the texture subresource layout core
// per start the level walk runs once for each of the clamped mip levels:
// block-count divisions, multiplies, align remainder division, table write;
// then a total step and records one per cycle; a layer error gives one beat
// throughput: next start taken in the cycle of the last beat, the receiver cannot stall
// rst is synchronous: config returns to reset values, control goes idle, no beat pending
`default_nettype none
`include "texture_subresource_layout_core_defines.svh"
module texture_subresource_layout_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [14:0] tex_width,
  input  wire logic [14:0] tex_height,
  input  wire logic [11:0] tex_depth,
  input  wire logic [3:0]  level_count,
  input  wire logic [11:0] array_count,
  input  wire logic        cube_mode,
  input  wire logic [13:0] layer_index,
  output logic             valid,
  output logic [31:0]      byte_offset,
  output logic [31:0]      byte_size,
  output logic [14:0]      row_texels,
  output logic [14:0]      row_count,
  output logic [3:0]       level_number,
  output logic [31:0]      total_bytes,
  output logic             status,
  output logic             last
);

  tsl_pkg::cmd_t cmd;
  tsl_pkg::sts_t sts;

  tsl_ctrl u_ctrl (
    .clk,
    .rst,
    .start,
    .sts,
    .cmd,
    .busy
  );

  tsl_dp u_dp (
    .clk,
    .rst,
    .cfg_wen,
    .cfg_index,
    .cfg_data,
    .tex_width,
    .tex_height,
    .tex_depth,
    .level_count,
    .array_count,
    .cube_mode,
    .layer_index,
    .cmd,
    .sts,
    .valid,
    .byte_offset,
    .byte_size,
    .row_texels,
    .row_count,
    .level_number,
    .total_bytes,
    .status,
    .last
  );

  `TSL_ASSERT_IMPL(a_err_last, clk, rst, valid && status, last && (level_number == 4'd0), "error beat not final")
  `TSL_ASSERT_NEXT(a_beats_run, clk, rst, valid && !last, valid && !status, "gap in record beats")
  `TSL_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !valid, "accepted item not busy")
  `TSL_ASSERT_NEXT(a_level_step, clk, rst, valid && !last, level_number == $past(level_number) + 4'd1, "level order broken")

endmodule
`default_nettype wire

@@ dv/texture_subresource_layout_core_tb.sv @@
// self-checking testbench for the texture subresource layout core
`default_nettype none
module texture_subresource_layout_core_tb;
  import tsl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_REPORTS = 200;
  localparam logic STAT_OK = 1'b0;
  localparam logic STAT_LAYER_ERR = 1'b1;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 16;

  typedef struct packed {
    logic [14:0] width;
    logic [14:0] height;
    logic [11:0] depth;
    logic [3:0]  levels;
    logic [11:0] arrays;
    logic        cube;
    logic [13:0] layer;
  } tex_desc_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic [14:0] texels;
    logic [14:0] rows;
    logic [3:0]  level;
    logic [31:0] total;
    logic        stat;
    logic        fin;
  } layout_rec_t;

  class layout_scoreboard;
    logic [4:0] bbytes;
    logic [3:0] bw_cfg;
    logic [3:0] bh_cfg;
    logic [3:0] bd_cfg;
    logic [8:0] align_cfg;
    layout_rec_t pending[$];
    int unsigned errors;

    function new();
      bbytes = RST_BLOCK_BYTES;
      bw_cfg = RST_BLOCK_DIM;
      bh_cfg = RST_BLOCK_DIM;
      bd_cfg = RST_BLOCK_DIM;
      align_cfg = RST_ALIGN_BYTES;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [8:0] data);
      case (idx)
        CFG_BLOCK_BYTES: bbytes = data[4:0];
        CFG_BLOCK_WIDTH: bw_cfg = data[3:0];
        CFG_BLOCK_HEIGHT: bh_cfg = data[3:0];
        CFG_BLOCK_DEPTH: bd_cfg = data[3:0];
        CFG_ALIGN_BYTES: align_cfg = data;
        default: ;
      endcase
    endfunction

    function logic [31:0] block_dim(logic [3:0] bdim);
      return (bdim == 0) ? 32'd1 : 32'(bdim);
    endfunction

    function logic [31:0] blocks(logic [31:0] dim, int lvl, logic [3:0] bdim);
      logic [31:0] ext;
      logic [31:0] b;
      ext = dim >> lvl;
      if (ext == 0) ext = 1;
      b = block_dim(bdim);
      return (ext + b - 1) / b;
    endfunction

    function logic [31:0] level_bytes(tex_desc_t d, int lvl);
      logic [63:0] s;
      s = 64'(bbytes) * 64'(blocks(32'(d.width), lvl, bw_cfg));
      s = (s * 64'(blocks(32'(d.height), lvl, bh_cfg))) & 64'hFFFF_FFFF;
      s = (s * 64'(blocks(32'(d.depth), lvl, bd_cfg))) & 64'hFFFF_FFFF;
      return s[31:0];
    endfunction

    function logic [31:0] slot_bytes(logic [31:0] size);
      logic [63:0] a;
      logic [63:0] r;
      a = (align_cfg == 0) ? 64'd1 : 64'(align_cfg);
      r = ((64'(size) + a - 1) / a) * a;
      return r[31:0];
    endfunction

    function void note_item(tex_desc_t d);
      int levels;
      logic [31:0] layers;
      logic [31:0] stride;
      logic [31:0] total;
      logic [31:0] off;
      logic [31:0] sz;
      layout_rec_t r;
      levels = (d.levels == 0) ? 1 : int'(d.levels);
      if (levels > MAX_LEVELS) levels = MAX_LEVELS;
      layers = d.cube ? 32'(d.arrays) * 32'd6 : 32'(d.arrays);
      stride = 0;
      for (int l = 0; l < levels; l++) stride += slot_bytes(level_bytes(d, l));
      total = 32'(64'(layers) * 64'(stride));
      if (32'(d.layer) >= layers) begin
        r = '0;
        r.total = total;
        r.stat = STAT_LAYER_ERR;
        r.fin = 1'b1;
        pending.push_back(r);
        return;
      end
      off = 32'(64'(d.layer) * 64'(stride));
      for (int l = 0; l < levels; l++) begin
        sz = level_bytes(d, l);
        r.offset = off;
        r.size = sz;
        r.texels = 15'(blocks(32'(d.width), l, bw_cfg) * block_dim(bw_cfg));
        r.rows = 15'(blocks(32'(d.height), l, bh_cfg) * block_dim(bh_cfg));
        r.level = 4'(l);
        r.total = total;
        r.stat = STAT_OK;
        r.fin = (l + 1 == levels);
        pending.push_back(r);
        off += slot_bytes(sz);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_beat(layout_rec_t got);
      layout_rec_t want;
      if (pending.size() == 0) begin
        report("beat with no record pending");
        return;
      end
      want = pending.pop_front();
      cmp_field("byte_offset", got.offset, want.offset);
      cmp_field("byte_size", got.size, want.size);
      cmp_field("row_texels", 32'(got.texels), 32'(want.texels));
      cmp_field("row_count", 32'(got.rows), 32'(want.rows));
      cmp_field("level_number", 32'(got.level), 32'(want.level));
      cmp_field("total_bytes", got.total, want.total);
      cmp_field("status", 32'(got.stat), 32'(want.stat));
      cmp_field("last", 32'(got.fin), 32'(want.fin));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [14:0] tex_width = '0;
  logic [14:0] tex_height = '0;
  logic [11:0] tex_depth = '0;
  logic [3:0]  level_count = '0;
  logic [11:0] array_count = '0;
  logic        cube_mode = 1'b0;
  logic [13:0] layer_index = '0;
  logic        valid;
  logic [31:0] byte_offset;
  logic [31:0] byte_size;
  logic [14:0] row_texels;
  logic [14:0] row_count;
  logic [3:0]  level_number;
  logic [31:0] total_bytes;
  logic        status;
  logic        last;

  int unsigned cycles = 0;
  layout_scoreboard sb = new();

  texture_subresource_layout_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .tex_width(tex_width),
    .tex_height(tex_height),
    .tex_depth(tex_depth),
    .level_count(level_count),
    .array_count(array_count),
    .cube_mode(cube_mode),
    .layer_index(layer_index),
    .valid(valid),
    .byte_offset(byte_offset),
    .byte_size(byte_size),
    .row_texels(row_texels),
    .row_count(row_count),
    .level_number(level_number),
    .total_bytes(total_bytes),
    .status(status),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && valid) begin
      sb.check_beat('{byte_offset, byte_size, row_texels, row_count, level_number,
                      total_bytes, status, last});
    end
  end

  function automatic tex_desc_t desc(int w, int h, int d, int lv, int arr, int cb,
                                     int layer);
    return '{15'(w), 15'(h), 12'(d), 4'(lv), 12'(arr), 1'(cb), 14'(layer)};
  endfunction

  function automatic tex_desc_t rand_desc();
    tex_desc_t d;
    int unsigned layers;
    int unsigned top;
    if ($urandom_range(9) == 0) begin
      // noise across every bit of every field
      d.width = 15'($urandom_range(32767));
      d.height = 15'($urandom_range(32767));
      d.depth = 12'($urandom_range(4095));
      d.levels = 4'($urandom_range(15));
      d.arrays = 12'($urandom_range(4095));
      d.cube = 1'($urandom_range(1));
      d.layer = 14'($urandom_range(16383));
      return d;
    end
    d.width = 15'($urandom_range(1) ? $urandom_range(1, 64) : $urandom_range(1, 16384));
    d.height = 15'($urandom_range(1) ? $urandom_range(1, 64) : $urandom_range(1, 16384));
    d.depth = 12'(($urandom_range(3) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 4));
    d.levels = 4'($urandom_range(1, 15));
    d.arrays = 12'(($urandom_range(4) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 8));
    d.cube = 1'($urandom_range(1));
    layers = d.cube ? 6 * d.arrays : d.arrays;
    top = (layers > 16384) ? 16384 : layers;
    if ($urandom_range(9) == 0 && layers < 16384)
      d.layer = 14'($urandom_range(layers, (layers + 3 > 16383) ? 16383 : layers + 3));
    else
      d.layer = 14'($urandom_range(top - 1));
    return d;
  endfunction

  task automatic issue(tex_desc_t d, int idle_pct);
    bit go;
    tex_width <= d.width;
    tex_height <= d.height;
    tex_depth <= d.depth;
    level_count <= d.levels;
    array_count <= d.arrays;
    cube_mode <= d.cube;
    layer_index <= d.layer;
    do begin
      go = ($urandom_range(99) >= idle_pct);
      start <= go;
      @(posedge clk);
    end while (!go || busy);
    sb.note_item(d);
  endtask

  // hold off until every pending record has come back and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [8:0] data);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(int bb, int bw, int bh, int bd, int al);
    write_reg(CFG_BLOCK_BYTES, 9'(bb));
    write_reg(CFG_BLOCK_WIDTH, 9'(bw));
    write_reg(CFG_BLOCK_HEIGHT, 9'(bh));
    write_reg(CFG_BLOCK_DEPTH, 9'(bd));
    write_reg(CFG_ALIGN_BYTES, 9'(al));
    cfg_wen <= 1'b0;
  endtask

  initial begin
    int idle_pcts[3];
    idle_pcts = '{0, 50, 31};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values
    issue(desc(1, 1, 1, 1, 1, 0, 0), 0);
    issue(desc(16384, 16384, 2048, 15, 2048, 1, 12287), 0);
    issue(desc(32767, 32767, 4095, 15, 4095, 1, 16383), 0);
    issue(desc(0, 0, 0, 3, 1, 0, 0), 0);
    issue(desc(8, 8, 1, 0, 1, 0, 0), 0);
    issue(desc(4, 4, 1, 2, 1, 0, 1), 0);
    issue(desc(4, 4, 1, 2, 0, 0, 0), 0);
    issue(desc(16, 16, 1, 5, 1, 1, 5), 0);
    issue(desc(16, 16, 1, 5, 1, 1, 6), 0);
    drain();

    // zero block dims and zero alignment
    configure(3, 0, 0, 0, 0);
    issue(desc(13, 7, 5, 4, 2, 0, 1), 0);
    issue(desc(1, 1, 1, 15, 1, 0, 0), 0);
    drain();

    // all-ones register data, upper bits masked off
    configure(511, 511, 511, 511, 511);
    issue(desc(16384, 16384, 2048, 15, 2048, 1, 0), 0);
    issue(desc(32767, 1, 4095, 15, 3, 0, 2), 0);
    issue(desc(100, 200, 1, 8, 4, 1, 23), 0);
    issue(desc(3, 3, 3, 2, 1, 0, 0), 0);
    drain();

    configure(1, 1, 1, 1, 1);
    issue(desc(16384, 16384, 2048, 15, 2048, 1, 12287), 0);
    issue(desc(2, 2, 1, 2, 1, 0, 0), 0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0)
        configure(16, 4, 4, 1, 256);
      else if (ph == 1)
        configure(4, 1, 1, 1, 4);
      else
        configure($urandom_range(511), $urandom_range(511), $urandom_range(511),
                  $urandom_range(511), $urandom_range(511));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) issue(rand_desc(), idle_pcts[ph % 3]);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) sb.report("records still pending at end of run");
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tsl_pkg.sv
rtl/core/tsl_div.sv
rtl/core/tsl_ctrl.sv
rtl/core/tsl_dp.sv
rtl/core/texture_subresource_layout_core.sv
dv/texture_subresource_layout_core_tb.sv
